### rtl/core/hrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_pkg
// shared types, constants and helpers for the hsv to rgb led dimmer core
// ----------------------------------------------------------------------------
package hrd_pkg;

	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [7:0]  LEVEL_FULL  = 8'd255;
	localparam logic [8:0]  BRIGHT_FULL = 9'd256;
	localparam logic [8:0]  FRAC_SCALE  = 9'd256;
	localparam logic [15:0] QT_DENOM    = 16'd65280;
	// reciprocal of 255 in 1.23 fixed point, exact for any 16-bit dividend
	localparam logic [15:0] RECIP_255   = 16'h8081;

	// hue sectors, named by the color span they cover
	typedef enum logic [2:0] {
		SEC_R_TO_Y = 3'd0,
		SEC_Y_TO_G = 3'd1,
		SEC_G_TO_C = 3'd2,
		SEC_C_TO_B = 3'd3,
		SEC_B_TO_M = 3'd4,
		SEC_M_TO_R = 3'd5
	} sector_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_LIMIT   = 8'd0,
		CFG_GREEN_LIMIT = 8'd1,
		CFG_BLUE_LIMIT  = 8'd2,
		CFG_BRIGHTNESS  = 8'd3
	} cfg_idx_t;

	// active settings as seen by the dimming stages
	typedef struct packed {
		logic [7:0] red_limit;
		logic [7:0] green_limit;
		logic [7:0] blue_limit;
		logic [8:0] bright;
	} dim_cfg_t;

	// converter output, before the sector select
	typedef struct packed {
		sector_t    sector;
		logic [7:0] v;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
	} pqt_t;

	typedef struct packed {
		logic [7:0] blue_duty;
		logic [7:0] green_duty;
		logic [7:0] red_duty;
		logic [7:0] blue_level;
		logic [7:0] green_level;
		logic [7:0] red_level;
	} result_t;

	// floor(x / 255) by reciprocal multiply
	function automatic logic [8:0] div255(input logic [15:0] x);
		logic [31:0] m;
		m = 32'(x) * 32'(RECIP_255);
		return m[31:23];
	endfunction

endpackage

### rtl/core/hrd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_cfg
// configuration register file: channel limits and global brightness
// ----------------------------------------------------------------------------
module hrd_cfg import hrd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [8:0]           cfg_data,
	output dim_cfg_t             dim_cfg
);

	logic [7:0] red_limit_q;
	logic [7:0] green_limit_q;
	logic [7:0] blue_limit_q;
	logic [8:0] brightness_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_limit_q   <= LEVEL_FULL;
			green_limit_q <= LEVEL_FULL;
			blue_limit_q  <= LEVEL_FULL;
			brightness_q  <= BRIGHT_FULL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RED_LIMIT:   red_limit_q   <= cfg_data[7:0];
				CFG_GREEN_LIMIT: green_limit_q <= cfg_data[7:0];
				CFG_BLUE_LIMIT:  blue_limit_q  <= cfg_data[7:0];
				CFG_BRIGHTNESS:  brightness_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		dim_cfg.red_limit   = red_limit_q;
		dim_cfg.green_limit = green_limit_q;
		dim_cfg.blue_limit  = blue_limit_q;
		// anything with bit 8 set is at or above full scale
		dim_cfg.bright      = brightness_q[8] ? BRIGHT_FULL : brightness_q;
	end

endmodule

### rtl/core/hrd_hsv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_hsv
// three-stage converter forming the p, q and t terms of an hsv color
// ----------------------------------------------------------------------------
module hrd_hsv import hrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [10:0] hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness_value,
	output logic        out_valid,
	input  logic        out_ready,
	output pqt_t        out_data
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        ready_s1, ready_s2, ready_s3;

	sector_t     sector_s1, sector_s2, sector_s3;
	logic [7:0]  v_s1, v_s2, v_s3;
	logic [15:0] vs_s1;
	logic [15:0] fs_s1;
	logic [15:0] gs_s1;
	logic [7:0]  p_s2, p_s3;
	logic [23:0] qn_s2;
	logic [23:0] tn_s2;
	logic [7:0]  q_s3;
	logic [7:0]  t_s3;

	sector_t     sector_in;
	logic [8:0]  inv_frac;
	logic [8:0]  p_div;
	logic [8:0]  q_div;
	logic [8:0]  t_div;

	// a stage takes new data when it is empty or its successor takes its data
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// sectors six and seven wrap onto zero and one
	always_comb begin
		unique case (hue[10:8])
			3'd0:    sector_in = SEC_R_TO_Y;
			3'd1:    sector_in = SEC_Y_TO_G;
			3'd2:    sector_in = SEC_G_TO_C;
			3'd3:    sector_in = SEC_C_TO_B;
			3'd4:    sector_in = SEC_B_TO_M;
			3'd5:    sector_in = SEC_M_TO_R;
			3'd6:    sector_in = SEC_R_TO_Y;
			default: sector_in = SEC_Y_TO_G;
		endcase
	end

	assign inv_frac = FRAC_SCALE - {1'b0, hue[7:0]};
	assign p_div    = div255(vs_s1);
	assign q_div    = div255(qn_s2[23:8]);
	assign t_div    = div255(tn_s2[23:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			sector_s1 <= sector_in;
			v_s1      <= brightness_value;
			vs_s1     <= 16'(brightness_value) * 16'(LEVEL_FULL - saturation);
			fs_s1     <= 16'(hue[7:0]) * 16'(saturation);
			gs_s1     <= 16'(inv_frac) * 16'(saturation);
		end
		if (ready_s2) begin
			sector_s2 <= sector_s1;
			v_s2      <= v_s1;
			p_s2      <= p_div[7:0];
			qn_s2     <= 24'(v_s1) * 24'(QT_DENOM - fs_s1);
			tn_s2     <= 24'(v_s1) * 24'(QT_DENOM - gs_s1);
		end
		if (ready_s3) begin
			sector_s3 <= sector_s2;
			v_s3      <= v_s2;
			p_s3      <= p_s2;
			q_s3      <= q_div[7:0];
			t_s3      <= t_div[7:0];
		end
	end

	assign out_valid       = valid_s3;
	assign out_data.sector = sector_s3;
	assign out_data.v      = v_s3;
	assign out_data.p      = p_s3;
	assign out_data.q      = q_s3;
	assign out_data.t      = t_s3;

endmodule

### rtl/core/hrd_dim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_dim
// sector select and three-stage pwm duty scaling by limit and brightness
// ----------------------------------------------------------------------------
module hrd_dim import hrd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  dim_cfg_t dim_cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  pqt_t     in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_data
);

	logic        valid_s4, valid_s5, valid_s6;
	logic        ready_s4, ready_s5, ready_s6;

	logic [7:0]  r_sel, g_sel, b_sel;
	logic [7:0]  r_s4, g_s4, b_s4;
	logic [15:0] rl_s4, gl_s4, bl_s4;
	logic [7:0]  r_s5, g_s5, b_s5;
	logic [23:0] rb_s5, gb_s5, bb_s5;
	logic [8:0]  r_div, g_div, b_div;
	result_t     res_s6;

	assign ready_s6 = !valid_s6 || out_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign in_ready = ready_s4;

	always_comb begin
		unique case (in_data.sector)
			SEC_R_TO_Y: begin
				r_sel = in_data.v; g_sel = in_data.t; b_sel = in_data.p;
			end
			SEC_Y_TO_G: begin
				r_sel = in_data.q; g_sel = in_data.v; b_sel = in_data.p;
			end
			SEC_G_TO_C: begin
				r_sel = in_data.p; g_sel = in_data.v; b_sel = in_data.t;
			end
			SEC_C_TO_B: begin
				r_sel = in_data.p; g_sel = in_data.q; b_sel = in_data.v;
			end
			SEC_B_TO_M: begin
				r_sel = in_data.t; g_sel = in_data.p; b_sel = in_data.v;
			end
			default: begin
				r_sel = in_data.v; g_sel = in_data.p; b_sel = in_data.q;
			end
		endcase
	end

	// level * limit * brightness / 65280 is floor(floor(x / 256) / 255)
	assign r_div = div255(rb_s5[23:8]);
	assign g_div = div255(gb_s5[23:8]);
	assign b_div = div255(bb_s5[23:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s4) valid_s4 <= in_valid;
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			r_s4  <= r_sel;
			g_s4  <= g_sel;
			b_s4  <= b_sel;
			rl_s4 <= 16'(r_sel) * 16'(dim_cfg.red_limit);
			gl_s4 <= 16'(g_sel) * 16'(dim_cfg.green_limit);
			bl_s4 <= 16'(b_sel) * 16'(dim_cfg.blue_limit);
		end
		if (ready_s5) begin
			r_s5  <= r_s4;
			g_s5  <= g_s4;
			b_s5  <= b_s4;
			rb_s5 <= 24'(rl_s4) * 24'(dim_cfg.bright);
			gb_s5 <= 24'(gl_s4) * 24'(dim_cfg.bright);
			bb_s5 <= 24'(bl_s4) * 24'(dim_cfg.bright);
		end
		if (ready_s6) begin
			res_s6.red_level   <= r_s5;
			res_s6.green_level <= g_s5;
			res_s6.blue_level  <= b_s5;
			res_s6.red_duty    <= r_div[7:0];
			res_s6.green_duty  <= g_div[7:0];
			res_s6.blue_duty   <= b_div[7:0];
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = res_s6;

endmodule

### rtl/core/hsv_to_rgb_led_dimmer_core.sv
`timescale 1ns / 1ps
// pipeline: an accepted input transaction passes registers s1 to s6 before its result is on m_axis
// throughput: one color per cycle while m_axis is not stalled, set by the six-stage multiply pipeline
// each stage has its own valid bit, so bubbles close up while m_axis stalls
// reset: arst_n clears all valid bits; limits reset to 255, brightness to 256
// ----------------------------------------------------------------------------
// hsv_to_rgb_led_dimmer_core
// hsv to rgb conversion with per-channel pwm limit and global brightness
// ----------------------------------------------------------------------------
module hsv_to_rgb_led_dimmer_core import hrd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [10:0] hue, [18:11] saturation, [26:19] brightness_value, [31:27] zero
	input  logic [31:0]          s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [7:0] red_level, [15:8] green_level, [23:16] blue_level,
	// [31:24] red_duty, [39:32] green_duty, [47:40] blue_duty
	output logic [47:0]          m_axis_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [8:0]           cfg_data
);

	dim_cfg_t dim_cfg;
	pqt_t     pqt;
	logic     pqt_valid;
	logic     pqt_ready;
	result_t  result;

	hrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dim_cfg   (dim_cfg)
	);

	hrd_hsv u_hsv (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (s_axis_tvalid),
		.in_ready         (s_axis_tready),
		.hue              (s_axis_tdata[10:0]),
		.saturation       (s_axis_tdata[18:11]),
		.brightness_value (s_axis_tdata[26:19]),
		.out_valid        (pqt_valid),
		.out_ready        (pqt_ready),
		.out_data         (pqt)
	);

	hrd_dim u_dim (
		.clk       (clk),
		.arst_n    (arst_n),
		.dim_cfg   (dim_cfg),
		.in_valid  (pqt_valid),
		.in_ready  (pqt_ready),
		.in_data   (pqt),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result)
	);

	assign m_axis_tdata = result;

endmodule

### rtl/core/hrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrd_checker
// port-level checks for the hsv to rgb led dimmer core
// ----------------------------------------------------------------------------
module hrd_checker import hrd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	// a stalled result transaction keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// dimming never raises a channel above its level
	a_duty_le_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:24] <= m_axis_tdata[7:0]) &&
			(m_axis_tdata[39:32] <= m_axis_tdata[15:8]) &&
			(m_axis_tdata[47:40] <= m_axis_tdata[23:16]))
		else $error("duty above level");

	// input back-pressure only when the pipeline is full up to the output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// a free-running sink never stalls the source
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output ready");

endmodule

bind hsv_to_rgb_led_dimmer_core hrd_checker u_hrd_checker (.*);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the hsv to rgb led dimmer core: a table of directed
// colors, then phases of random colors under changing limits and brightness,
// each result checked field by field against its table entry or a local fixed-point predictor
// ----------------------------------------------------------------------------
module tb;
	import hrd_pkg::*;

	localparam int PHASES          = 8;
	localparam int COLORS_PER_PHASE = 118;
	localparam int IDLE_LIMIT      = 4000;
	localparam int DRAIN_CYCLES    = 24;
	localparam int HOLD_CYCLES     = 300;
	localparam int REPORT_MAX      = 10;
	localparam int unsigned SECTOR_COUNT = 6;
	localparam int unsigned FULL   = LEVEL_FULL;
	localparam int unsigned FRAC   = FRAC_SCALE;
	localparam int unsigned QT     = QT_DENOM;
	localparam int unsigned BFULL  = BRIGHT_FULL;
	localparam int unsigned IDX_SPARE_LO = int'(CFG_BRIGHTNESS) + 1;
	localparam int unsigned IDX_SPARE_HI = (1 << CFG_IDX_W) - 1;

	typedef struct packed {
		logic [10:0] hue;
		logic [7:0]  sat;
		logic [7:0]  val;
		bit          typed;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  rd;
		logic [7:0]  gd;
		logic [7:0]  bd;
	} color_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [47:0]          m_axis_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [8:0]           cfg_data;

	// predictor copy of the dimming registers
	logic [7:0] lim_red;
	logic [7:0] lim_green;
	logic [7:0] lim_blue;
	logic [8:0] dim_bright;

	result_t    pending_colors[$];
	result_t    want;
	result_t    got;
	color_row_t directed_rows [0:20];

	int  mismatches;
	int  colors_sent;
	int  results_checked;
	int  cfg_writes;
	int  stuck_cycles;
	int  rx_wait;
	int  hold_left;
	bit  hold_request;
	bit  tx_idling;
	bit  rx_idling;

	hsv_to_rgb_led_dimmer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(6, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 8'd0;
		else if (r < 16)
			return LEVEL_FULL;
		else
			return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] dim_level(logic [7:0] level, logic [7:0] lim);
		int unsigned br;
		int unsigned prod;
		br = (dim_bright > BRIGHT_FULL) ? BFULL : int'(dim_bright);
		prod = int'(level) * int'(lim) * br;
		return 8'(prod / (FULL * BFULL));
	endfunction

	function automatic result_t convert_color(logic [10:0] hue, logic [7:0] sat,
			logic [7:0] val);
		int unsigned v, s, f, p, q, t, r, g, b;
		sector_t sec;
		result_t res;
		v = val;
		s = sat;
		f = hue[7:0];
		sec = sector_t'(int'(hue[10:8]) % SECTOR_COUNT);
		p = v * (FULL - s) / FULL;
		q = v * (QT - f * s) / QT;
		t = v * (QT - (FRAC - f) * s) / QT;
		case (sec)
			SEC_R_TO_Y: begin r = v; g = t; b = p; end
			SEC_Y_TO_G: begin r = q; g = v; b = p; end
			SEC_G_TO_C: begin r = p; g = v; b = t; end
			SEC_C_TO_B: begin r = p; g = q; b = v; end
			SEC_B_TO_M: begin r = t; g = p; b = v; end
			default:    begin r = v; g = p; b = q; end
		endcase
		res.red_level   = 8'(r);
		res.green_level = 8'(g);
		res.blue_level  = 8'(b);
		res.red_duty    = dim_level(res.red_level, lim_red);
		res.green_duty  = dim_level(res.green_level, lim_green);
		res.blue_duty   = dim_level(res.blue_level, lim_blue);
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("%0t mismatch on %s: expected %0d, got %0d", $realtime, name,
					exp_v, act_v);
		end
	endtask

	// output side: compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata);
			if (pending_colors.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t unexpected result %h", $realtime, m_axis_tdata);
			end else begin
				want = pending_colors.pop_front();
				results_checked++;
				check_field("red_level", want.red_level, got.red_level);
				check_field("green_level", want.green_level, got.green_level);
				check_field("blue_level", want.blue_level, got.blue_level);
				check_field("red_duty", want.red_duty, got.red_duty);
				check_field("green_duty", want.green_duty, got.green_duty);
				check_field("blue_duty", want.blue_duty, got.blue_duty);
			end
		end
	end

	// watchdog: nothing accepted on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= IDLE_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $realtime, IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver: random stalls, plus a long hold on request
	initial begin
		m_axis_tready = 1'b0;
		rx_wait = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (rx_idling)
					rx_wait = pick_gap();
			end
		end
	end

	task automatic push_color(input logic [10:0] hue, input logic [7:0] sat,
			input logic [7:0] val, input bit typed, input result_t typed_res);
		int gap;
		gap = tx_idling ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, val, sat, hue};
		do @(posedge clk); while (!s_axis_tready);
		pending_colors.push_back(typed ? typed_res : convert_color(hue, sat, val));
		colors_sent++;
	endtask

	// lower valid and wait until every color in flight has come back
	task automatic drain_colors();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_RED_LIMIT:   lim_red    = data[7:0];
			CFG_GREEN_LIMIT: lim_green  = data[7:0];
			CFG_BLUE_LIMIT:  lim_blue   = data[7:0];
			CFG_BRIGHTNESS:  dim_bright = data;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [8:0] red, input logic [8:0] green,
			input logic [8:0] blue, input logic [8:0] bright);
		write_reg(CFG_RED_LIMIT, red);
		write_reg(CFG_GREEN_LIMIT, green);
		write_reg(CFG_BLUE_LIMIT, blue);
		write_reg(CFG_BRIGHTNESS, bright);
	endtask

	initial begin
		color_row_t row;
		result_t    typed_res;
		logic [10:0] hue;

		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		hold_request  = 1'b0;
		tx_idling     = 1'b1;
		rx_idling     = 1'b1;
		mismatches    = 0;
		colors_sent   = 0;
		results_checked = 0;
		cfg_writes    = 0;
		stuck_cycles  = 0;
		lim_red       = LEVEL_FULL;
		lim_green     = LEVEL_FULL;
		lim_blue      = LEVEL_FULL;
		dim_bright    = BRIGHT_FULL;

		// hue, sat, val, typed, levels r g b, duties r g b
		directed_rows = '{
			'{11'd0,    8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0},
			'{11'd256,  8'd255, 8'd255, 1'b1, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0},
			'{11'd512,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0},
			'{11'd768,  8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255, 8'd255},
			'{11'd1024, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd255},
			'{11'd1280, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd255, 8'd255, 8'd0,   8'd255},
			'{11'd1535, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0},
			// sectors six and seven wrap onto zero and one
			'{11'd1536, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0,   8'd255, 8'd0,   8'd0},
			'{11'd2047, 8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0},
			'{11'd0,    8'd0,   8'd255, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255},
			'{11'd2047, 8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
			'{11'd777,  8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0},
			'{11'd128,  8'd200, 8'd180, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd300,  8'd128, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd640,  8'd77,  8'd99,  1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd900,  8'd255, 8'd128, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd1100, 8'd33,  8'd201, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd1400, 8'd160, 8'd60,  1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd1791, 8'd90,  8'd222, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd255,  8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{11'd1983, 8'd1,   8'd1,   1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed colors under reset settings
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			typed_res.red_level   = row.r;
			typed_res.green_level = row.g;
			typed_res.blue_level  = row.b;
			typed_res.red_duty    = row.rd;
			typed_res.green_duty  = row.gd;
			typed_res.blue_duty   = row.bd;
			push_color(row.hue, row.sat, row.val, row.typed, typed_res);
		end
		drain_colors();

		for (int k = 0; k < PHASES; k++) begin
			case (k)
				0: begin
					write_all(9'd0, 9'd255, 9'd128, 9'd0);
					write_reg(CFG_IDX_W'(IDX_SPARE_LO), 9'd511);
				end
				1: write_all(9'd511, 9'd255, 9'd511, 9'd256);
				// brightness above full is clamped
				2: write_all(9'd255, 9'd0, 9'd255, 9'd511);
				3: write_all(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
					9'($urandom_range(0, 511)), 9'd257);
				4: write_all(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
					9'($urandom_range(0, 511)), 9'd128);
				5: begin
					write_reg(CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI)), 9'd0);
					write_all(9'd1, 9'd254, 9'd256, 9'd1);
				end
				default: write_all(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
					9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
			endcase

			tx_idling = (k != 1) && (k != 3) && (k != 4);
			rx_idling = (k != 1) && (k != 6);
			// long output stall while input keeps coming, so the pipe backs up
			if (k == 3)
				hold_request = 1'b1;

			for (int n = 0; n < COLORS_PER_PHASE; n++) begin
				hue = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(1536, 2047))
					: 11'($urandom_range(0, 1535));
				push_color(hue, pick_byte(), pick_byte(), 1'b0, '0);
			end
			drain_colors();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_colors.size() != 0) begin
			$display("%0d expected results never arrived", pending_colors.size());
			mismatches += pending_colors.size();
		end

		$display("covered %0d colors (%0d from the table) and checked %0d results",
			colors_sent, $size(directed_rows), results_checked);
		$display("%0d register writes over %0d settings, with one %0d-cycle output hold",
			cfg_writes, PHASES + 1, HOLD_CYCLES);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
